// ===== src/mpd_pkg.sv =====
// Shared types and constants for the motion and presence detector.
package mpd_pkg;

  localparam int CELL_W    = 16;
  localparam int LUMA_W    = 8;
  localparam int MARK_W    = 8;
  localparam int THR_W     = 8;
  localparam int WGT_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int AVG_W     = LUMA_W + FRAC_W;
  localparam int DIFF_W    = AVG_W + 1;
  localparam int PROD_W    = DIFF_W + WGT_W + 1;
  localparam int STEP_W    = PROD_W - FRAC_W;
  localparam int MAX_CELLS = 65536;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int RAM_W     = 2 * AVG_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WGT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_WGT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WGT = 2'd3;

  localparam logic [THR_W-1:0] MOTION_THR_RST   = 8'd8;
  localparam logic [THR_W-1:0] PRESENCE_THR_RST = 8'd8;
  localparam logic [WGT_W-1:0] MOTION_WGT_RST   = 17'd6554;
  localparam logic [WGT_W-1:0] PRESENCE_WGT_RST = 17'd7;
  localparam logic [WGT_W-1:0] WEIGHT_ONE       = 17'h10000;

  localparam logic [MARK_W-1:0] MARK_HIT  = 8'd64;
  localparam logic [MARK_W-1:0] MARK_IDLE = 8'd128;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [LUMA_W-1:0] luma_top_left;
    logic [LUMA_W-1:0] luma_top_right;
    logic [LUMA_W-1:0] luma_bottom_left;
    logic [LUMA_W-1:0] luma_bottom_right;
    logic              seed_frame;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_out;
    logic [MARK_W-1:0] motion_mark;
    logic [MARK_W-1:0] presence_mark;
  } out_item_t;

endpackage

// ===== src/mpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written in that cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== src/motion_presence_detector.sv =====
// Top level of the motion and presence detector: four-stage update pipeline.
//
//   channel | ports                              | transfer when
//   --------+------------------------------------+-----------------------------
//   input   | in_valid, in_ready, in_data        | in_valid & in_ready
//   result  | out_valid, out_ready, out_data     | out_valid & out_ready
//   config  | cfg_wr_en, cfg_index, cfg_data     | cfg_wr_en
//
// One item per cycle unless the result channel stalls or a same-cell item must wait; a result
// is offered from the stage-four register. A non-seed item for the same cell as the item just
// ahead of it waits until that item reaches stage three, since the averages RAM read-modify-write
// loop forwards from stage three on. Reset clears the stage valid bits and the config registers;
// the RAM is not cleared. Each stage holds while the one after it is full and stalled.
module motion_presence_detector
  import mpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [THR_W-1:0] motion_thr_r;
  logic [THR_W-1:0] presence_thr_r;
  logic [WGT_W-1:0] motion_wgt_r;
  logic [WGT_W-1:0] presence_wgt_r;
  logic [WGT_W-1:0] cfg_wgt;

  logic rdy1, rdy2, rdy3, rdy4;
  logic hazard;

  logic [LUMA_W+1:0] luma_sum;

  logic              s1_valid_r;
  logic [CELL_W-1:0] s1_cell_r;
  logic [LUMA_W-1:0] s1_v_r;
  logic              s1_seed_r;
  logic [RAM_W-1:0]  ram_rd_data;
  logic [AVG_W-1:0]  s1_target;
  logic [AVG_W-1:0]  s1_rec;
  logic [AVG_W-1:0]  s1_bg;
  logic              fwd3, fwd4;
  logic [DIFF_W-1:0] s1_d_rec, s1_d_bg, s1_n_rec, s1_n_bg;

  logic              s2_valid_r;
  logic [CELL_W-1:0] s2_cell_r;
  logic [LUMA_W-1:0] s2_v_r;
  logic              s2_seed_r;
  logic [AVG_W-1:0]  s2_rec_r, s2_bg_r;
  logic [DIFF_W-1:0] s2_d_rec_r, s2_d_bg_r;
  logic [AVG_W-1:0]  s2_mag_rec_r, s2_mag_bg_r;
  logic signed [PROD_W-1:0] s2_p_rec, s2_p_bg;
  logic [MARK_W-1:0] s2_mmark, s2_pmark;

  logic              s3_valid_r;
  logic [CELL_W-1:0] s3_cell_r;
  logic [LUMA_W-1:0] s3_v_r;
  logic              s3_seed_r;
  logic [AVG_W-1:0]  s3_rec_r, s3_bg_r;
  logic [STEP_W-1:0] s3_step_rec_r, s3_step_bg_r;
  logic [MARK_W-1:0] s3_mmark_r, s3_pmark_r;
  logic [STEP_W-1:0] s3_sum_rec, s3_sum_bg;
  logic [AVG_W-1:0]  s3_new_rec, s3_new_bg;

  logic              s4_valid_r;
  logic [CELL_W-1:0] s4_cell_r;
  logic [AVG_W-1:0]  s4_rec_r, s4_bg_r;
  logic [MARK_W-1:0] s4_mmark_r, s4_pmark_r;

  logic ram_wr_en;

  // Weights above one are held as exactly one.
  assign cfg_wgt = (cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_thr_r   <= MOTION_THR_RST;
      presence_thr_r <= PRESENCE_THR_RST;
      motion_wgt_r   <= MOTION_WGT_RST;
      presence_wgt_r <= PRESENCE_WGT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MOTION_THR:   motion_thr_r   <= cfg_data[THR_W-1:0];
        CFG_PRESENCE_THR: presence_thr_r <= cfg_data[THR_W-1:0];
        CFG_MOTION_WGT:   motion_wgt_r   <= cfg_wgt;
        CFG_PRESENCE_WGT: presence_wgt_r <= cfg_wgt;
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or its contents move on.
  assign rdy4 = !s4_valid_r || out_ready;
  assign rdy3 = !s3_valid_r || rdy4;
  assign rdy2 = !s2_valid_r || rdy3;
  assign rdy1 = !s1_valid_r || rdy2;

  // A non-seed item may not sit in stage one right behind an item for the
  // same cell in stage two, because that item's new averages do not exist yet.
  always_comb begin
    if (rdy2) begin
      hazard = s1_valid_r && (in_data.cell_index == s1_cell_r);
    end else begin
      hazard = s2_valid_r && (in_data.cell_index == s2_cell_r);
    end
    hazard = hazard && !in_data.seed_frame;
  end

  assign in_ready = rdy1 && !hazard;

  assign luma_sum = {2'b00, in_data.luma_top_left} + {2'b00, in_data.luma_top_right}
                  + {2'b00, in_data.luma_bottom_left} + {2'b00, in_data.luma_bottom_right};

  assign ram_wr_en = s3_valid_r && rdy4;

  mpd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_CELLS)
  ) u_avg_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (s3_cell_r[ADDR_W-1:0]),
    .wr_data ({s3_new_rec, s3_new_bg}),
    .rd_en   (rdy1),
    .rd_addr (in_data.cell_index[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Stage 1: the RAM word arrives; newer values still in flight win over it.
  assign s1_target = {s1_v_r, {FRAC_W{1'b0}}};
  assign fwd3 = s3_valid_r && (s3_cell_r[ADDR_W-1:0] == s1_cell_r[ADDR_W-1:0]);
  assign fwd4 = s4_valid_r && (s4_cell_r[ADDR_W-1:0] == s1_cell_r[ADDR_W-1:0]);

  always_comb begin
    priority if (fwd3) begin
      s1_rec = s3_new_rec;
      s1_bg  = s3_new_bg;
    end else if (fwd4) begin
      s1_rec = s4_rec_r;
      s1_bg  = s4_bg_r;
    end else begin
      s1_rec = ram_rd_data[RAM_W-1:AVG_W];
      s1_bg  = ram_rd_data[AVG_W-1:0];
    end
  end

  assign s1_d_rec = {1'b0, s1_target} - {1'b0, s1_rec};
  assign s1_d_bg  = {1'b0, s1_target} - {1'b0, s1_bg};
  assign s1_n_rec = {1'b0, s1_rec} - {1'b0, s1_target};
  assign s1_n_bg  = {1'b0, s1_bg} - {1'b0, s1_target};

  // Stage 2: weight products and threshold compares.
  assign s2_p_rec = $signed(s2_d_rec_r) * $signed({1'b0, motion_wgt_r});
  assign s2_p_bg  = $signed(s2_d_bg_r) * $signed({1'b0, presence_wgt_r});

  always_comb begin
    s2_mmark = MARK_IDLE;
    s2_pmark = MARK_IDLE;
    if (!s2_seed_r) begin
      if (s2_mag_rec_r > {motion_thr_r, {FRAC_W{1'b0}}}) begin
        s2_mmark = MARK_HIT;
      end
      if (s2_mag_bg_r > {presence_thr_r, {FRAC_W{1'b0}}}) begin
        s2_pmark = MARK_HIT;
      end
    end
  end

  // Stage 3: new average is the old one plus the floored weighted step, or the cell's mean luma for a seed item.
  assign s3_sum_rec = {{(STEP_W-AVG_W){1'b0}}, s3_rec_r} + s3_step_rec_r;
  assign s3_sum_bg  = {{(STEP_W-AVG_W){1'b0}}, s3_bg_r} + s3_step_bg_r;
  assign s3_new_rec = s3_seed_r ? {s3_v_r, {FRAC_W{1'b0}}} : s3_sum_rec[AVG_W-1:0];
  assign s3_new_bg  = s3_seed_r ? {s3_v_r, {FRAC_W{1'b0}}} : s3_sum_bg[AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid_r <= in_valid && in_ready;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (rdy4) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_cell_r <= in_data.cell_index;
      s1_v_r    <= luma_sum[LUMA_W+1:2];
      s1_seed_r <= in_data.seed_frame;
    end
    if (rdy2) begin
      s2_cell_r    <= s1_cell_r;
      s2_v_r       <= s1_v_r;
      s2_seed_r    <= s1_seed_r;
      s2_rec_r     <= s1_rec;
      s2_bg_r      <= s1_bg;
      s2_d_rec_r   <= s1_d_rec;
      s2_d_bg_r    <= s1_d_bg;
      s2_mag_rec_r <= s1_d_rec[DIFF_W-1] ? s1_n_rec[AVG_W-1:0] : s1_d_rec[AVG_W-1:0];
      s2_mag_bg_r  <= s1_d_bg[DIFF_W-1] ? s1_n_bg[AVG_W-1:0] : s1_d_bg[AVG_W-1:0];
    end
    if (rdy3) begin
      s3_cell_r     <= s2_cell_r;
      s3_v_r        <= s2_v_r;
      s3_seed_r     <= s2_seed_r;
      s3_rec_r      <= s2_rec_r;
      s3_bg_r       <= s2_bg_r;
      s3_step_rec_r <= s2_p_rec[PROD_W-1:FRAC_W];
      s3_step_bg_r  <= s2_p_bg[PROD_W-1:FRAC_W];
      s3_mmark_r    <= s2_mmark;
      s3_pmark_r    <= s2_pmark;
    end
    if (rdy4) begin
      s4_cell_r  <= s3_cell_r;
      s4_rec_r   <= s3_new_rec;
      s4_bg_r    <= s3_new_bg;
      s4_mmark_r <= s3_mmark_r;
      s4_pmark_r <= s3_pmark_r;
    end
  end

  assign out_valid              = s4_valid_r;
  assign out_data.cell_out      = s4_cell_r;
  assign out_data.motion_mark   = s4_mmark_r;
  assign out_data.presence_mark = s4_pmark_r;

endmodule

// ===== src/mpd_checker.sv =====
// Port-level checks for the motion and presence detector, bound to the top level.
module mpd_checker
  import mpd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Reset empties the pipeline, so no result is offered right after it.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result stays in place until it is transferred.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.motion_mark == MARK_HIT || out_data.motion_mark == MARK_IDLE))
    else $error("motion mark is neither hit nor idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.presence_mark == MARK_HIT
                   || out_data.presence_mark == MARK_IDLE))
    else $error("presence mark is neither hit nor idle");

endmodule

bind motion_presence_detector mpd_checker u_mpd_checker (.*);
